>>> src/spq_pkg.sv
// Shared constants and types for the sorted priority queue.
package spq_pkg;

	localparam int unsigned OP_W     = 1;
	localparam int unsigned TAG_IN_W = 16;
	localparam int unsigned PRIO_W   = 4;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned FILL_W   = 8;

	typedef enum logic [OP_W-1:0] {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Broadcast from the control to every cell in the chain.
	typedef struct packed {
		logic              enq;
		logic              deq;
		logic [PRIO_W-1:0] prio;
	} spq_ctl_t;

endpackage

>>> src/spq_ifs.sv
// Valid/ready channel interfaces for the request and response beats.
interface spq_req_if;
	logic                          valid;
	logic                          ready;
	logic [spq_pkg::OP_W-1:0]      op;
	logic [spq_pkg::TAG_IN_W-1:0]  job_tag;
	logic [spq_pkg::PRIO_W-1:0]    request_priority;

	modport source(output valid, op, job_tag, request_priority, input ready);
	modport sink(input valid, op, job_tag, request_priority, output ready);
endinterface

interface spq_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [spq_pkg::STATUS_W-1:0]  status;
	logic [spq_pkg::TAG_IN_W-1:0]  out_tag;
	logic [spq_pkg::PRIO_W-1:0]    out_priority;
	logic [spq_pkg::FILL_W-1:0]    fill_count;

	modport source(output valid, status, out_tag, out_priority, fill_count, input ready);
	modport sink(input valid, status, out_tag, out_priority, fill_count, output ready);
endinterface

>>> src/spq_cell.sv
// One slot of the sorted chain: keeps, loads the new job, or takes a neighbor.
module spq_cell #(
	parameter int unsigned TAG_WIDTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  spq_pkg::spq_ctl_t           ctl,
	input  logic [TAG_WIDTH-1:0]        new_tag,
	input  logic                        prev_place,
	input  logic                        prev_valid,
	input  logic [TAG_WIDTH-1:0]        prev_tag,
	input  logic [spq_pkg::PRIO_W-1:0]  prev_prio,
	input  logic                        next_valid,
	input  logic [TAG_WIDTH-1:0]        next_tag,
	input  logic [spq_pkg::PRIO_W-1:0]  next_prio,
	output logic                        place,
	output logic                        valid,
	output logic [TAG_WIDTH-1:0]        tag,
	output logic [spq_pkg::PRIO_W-1:0]  prio
);

	logic                       valid_q;
	logic [TAG_WIDTH-1:0]       tag_q;
	logic [spq_pkg::PRIO_W-1:0] prio_q;

	// New job goes behind every job of equal or higher priority.
	assign place = !(valid_q && (prio_q >= ctl.prio));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.deq) begin
			valid_q <= next_valid;
		end else if (ctl.enq && place) begin
			valid_q <= prev_place ? prev_valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.deq) begin
			tag_q  <= next_tag;
			prio_q <= next_prio;
		end else if (ctl.enq && place) begin
			if (prev_place) begin
				tag_q  <= prev_tag;
				prio_q <= prev_prio;
			end else begin
				tag_q  <= new_tag;
				prio_q <= ctl.prio;
			end
		end
	end

	assign valid = valid_q;
	assign tag   = tag_q;
	assign prio  = prio_q;

endmodule

>>> src/sorted_priority_queue.sv
// A request beat yields its response beat from the result register in the next cycle.
// Throughput: one request per cycle while no response waits; every cell compares and shifts in the same cycle.
// A response that waits holds off new requests; a response taken in the same cycle
// frees the result register for the next request.
// Reset clears the slot valid chain, the fill count and the result valid; job
// tags and priorities are not reset and are only read once written.
module sorted_priority_queue #(
	parameter int unsigned DEPTH     = 128,
	parameter int unsigned TAG_WIDTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);

	localparam int unsigned OCC_W = $clog2(DEPTH + 1);

	logic                       cell_valid [DEPTH];
	logic                       cell_place [DEPTH];
	logic [TAG_WIDTH-1:0]       cell_tag   [DEPTH];
	logic [spq_pkg::PRIO_W-1:0] cell_prio  [DEPTH];
	logic [DEPTH-1:0]           valid_vec;

	logic [OCC_W-1:0]           occ_q;
	logic                       accept;
	logic                       full;
	logic                       empty;
	logic                       is_deq;

	spq_pkg::spq_ctl_t          ctl;
	logic [TAG_WIDTH+spq_pkg::TAG_IN_W-1:0] in_tag_ext;
	logic [TAG_WIDTH-1:0]       new_tag;
	logic [TAG_WIDTH+spq_pkg::TAG_IN_W-1:0] head_tag_ext;
	logic [OCC_W-1:0]           occ_next;
	logic [OCC_W+spq_pkg::FILL_W-1:0] fill_ext;

	logic                       rsp_valid_q;
	spq_pkg::status_t           status_q;
	logic [spq_pkg::TAG_IN_W-1:0] out_tag_q;
	logic [spq_pkg::PRIO_W-1:0] out_prio_q;
	logic [spq_pkg::FILL_W-1:0] fill_q;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign is_deq    = (req.op == spq_pkg::OP_DEQ);
	assign full      = cell_valid[DEPTH-1];
	assign empty     = !cell_valid[0];

	assign ctl.enq  = accept && !is_deq && !full;
	assign ctl.deq  = accept && is_deq && !empty;
	assign ctl.prio = req.request_priority;

	assign in_tag_ext = {{TAG_WIDTH{1'b0}}, req.job_tag};
	assign new_tag    = in_tag_ext[TAG_WIDTH-1:0];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                       p_place;
		logic                       p_valid;
		logic [TAG_WIDTH-1:0]       p_tag;
		logic [spq_pkg::PRIO_W-1:0] p_prio;
		logic                       n_valid;
		logic [TAG_WIDTH-1:0]       n_tag;
		logic [spq_pkg::PRIO_W-1:0] n_prio;

		if (i == 0) begin : g_head
			assign p_place = 1'b0;
			assign p_valid = 1'b0;
			assign p_tag   = '0;
			assign p_prio  = '0;
		end else begin : g_body
			assign p_place = cell_place[i-1];
			assign p_valid = cell_valid[i-1];
			assign p_tag   = cell_tag[i-1];
			assign p_prio  = cell_prio[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign n_valid = 1'b0;
			assign n_tag   = '0;
			assign n_prio  = '0;
		end else begin : g_inner
			assign n_valid = cell_valid[i+1];
			assign n_tag   = cell_tag[i+1];
			assign n_prio  = cell_prio[i+1];
		end

		spq_cell #(
			.TAG_WIDTH(TAG_WIDTH)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.new_tag   (new_tag),
			.prev_place(p_place),
			.prev_valid(p_valid),
			.prev_tag  (p_tag),
			.prev_prio (p_prio),
			.next_valid(n_valid),
			.next_tag  (n_tag),
			.next_prio (n_prio),
			.place     (cell_place[i]),
			.valid     (cell_valid[i]),
			.tag       (cell_tag[i]),
			.prio      (cell_prio[i])
		);

		assign valid_vec[i] = cell_valid[i];
	end

	always_comb begin
		occ_next = occ_q;
		if (ctl.enq) begin
			occ_next = occ_q + OCC_W'(1);
		end else if (ctl.deq) begin
			occ_next = occ_q - OCC_W'(1);
		end
	end

	assign head_tag_ext = {{spq_pkg::TAG_IN_W{1'b0}}, cell_tag[0]};
	assign fill_ext     = {{spq_pkg::FILL_W{1'b0}}, occ_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			occ_q <= occ_next;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Capture the result of each accepted request; hold it while stalled.
	always_ff @(posedge clk) begin
		if (accept) begin
			fill_q <= fill_ext[spq_pkg::FILL_W-1:0];
			if (ctl.deq) begin
				status_q   <= spq_pkg::ST_OK;
				out_tag_q  <= head_tag_ext[spq_pkg::TAG_IN_W-1:0];
				out_prio_q <= cell_prio[0];
			end else begin
				if (is_deq) begin
					status_q <= spq_pkg::ST_EMPTY;
				end else if (full) begin
					status_q <= spq_pkg::ST_FULL;
				end else begin
					status_q <= spq_pkg::ST_OK;
				end
				out_tag_q  <= '0;
				out_prio_q <= '0;
			end
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = status_q;
	assign rsp.out_tag      = out_tag_q;
	assign rsp.out_priority = out_prio_q;
	assign rsp.fill_count   = fill_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(DEPTH))
		else $error("fill count beyond depth");

	a_occ_matches_chain: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(occ_q))
		else $error("valid chain disagrees with fill count");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid[1] |-> (cell_prio[0] >= cell_prio[1]))
		else $error("head slot out of priority order");

	a_deq_result: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.deq |=> (rsp.valid && rsp.status == spq_pkg::ST_OK))
		else $error("dequeue did not report ok");

	a_enq_full: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !is_deq && full) |=> (occ_q == OCC_W'(DEPTH)
			&& rsp.status == spq_pkg::ST_FULL))
		else $error("enqueue into full queue changed state");

endmodule

>>> tb/sv/tb_sorted_priority_queue.sv
// Self-checking testbench for the sorted priority queue: directed and random job traffic against a queue model.
module tb_sorted_priority_queue;
	timeunit 1ns;
	timeprecision 1ps;

	import spq_pkg::*;

	localparam int unsigned QUEUE_DEPTH = 128;
	localparam int unsigned ITEM_TARGET = 950;
	localparam int unsigned HOLD_AT     = 60;
	localparam int unsigned HOLD_CYCLES = 300;

	typedef struct {
		op_t               op;
		logic [15:0]       tag;
		logic [PRIO_W-1:0] prio;
	} job_req_t;

	typedef struct {
		status_t           status;
		logic [15:0]       tag;
		logic [PRIO_W-1:0] prio;
		logic [FILL_W-1:0] fill;
	} job_rsp_t;

	typedef struct {
		logic [15:0]       tag;
		logic [PRIO_W-1:0] prio;
	} job_slot_t;

	logic clk;
	logic arst_n;

	spq_req_if req_ch();
	spq_rsp_if rsp_ch();

	sorted_priority_queue #(
		.DEPTH    (QUEUE_DEPTH),
		.TAG_WIDTH(16)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	job_req_t  pending_jobs[$];
	job_rsp_t  expected_rsp[$];
	job_slot_t queued_jobs[$];

	job_req_t cur_job;
	int       beats_in;
	int       total_jobs;
	int       errors;
	int       burst_left;
	int       gap_left;
	int       hold_cnt;
	logic     hold_done;
	logic [7:0] stall_pat;
	logic [5:0] stall_pos;

	int n_enq;
	int n_full;
	int n_deq;
	int n_empty;
	int max_fill;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Apply one job to the queue model and return the answer the block must give.
	function automatic job_rsp_t serve_job(job_req_t job);
		job_rsp_t  res;
		job_slot_t slot;
		int        pos;
		res.status = ST_OK;
		res.tag    = '0;
		res.prio   = '0;
		if (job.op == OP_ENQ) begin
			if (queued_jobs.size() >= QUEUE_DEPTH) begin
				res.status = ST_FULL;
			end else begin
				pos = queued_jobs.size();
				// insert behind every job of equal or higher priority
				while (pos > 0 && queued_jobs[pos-1].prio < job.prio)
					pos--;
				slot.tag  = job.tag;
				slot.prio = job.prio;
				queued_jobs.insert(pos, slot);
			end
		end else begin
			if (queued_jobs.size() == 0) begin
				res.status = ST_EMPTY;
			end else begin
				slot     = queued_jobs.pop_front();
				res.tag  = slot.tag;
				res.prio = slot.prio;
			end
		end
		res.fill = FILL_W'(queued_jobs.size());
		return res;
	endfunction

	task automatic add_job(op_t op, logic [15:0] tag, logic [PRIO_W-1:0] prio);
		job_req_t job;
		job.op   = op;
		job.tag  = tag;
		job.prio = prio;
		pending_jobs.push_back(job);
	endtask

	// Driver: bursts of beats separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		logic busy;
		if (!arst_n) begin
			req_ch.valid            <= 1'b0;
			req_ch.op               <= OP_ENQ;
			req_ch.job_tag          <= '0;
			req_ch.request_priority <= '0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			busy = req_ch.valid;
			if (req_ch.valid && req_ch.ready) begin
				expected_rsp.push_back(serve_job(cur_job));
				beats_in++;
				busy = 1'b0;
			end
			if (!busy) begin
				if (gap_left > 0) begin
					gap_left--;
					req_ch.valid <= 1'b0;
				end else if (pending_jobs.size() > 0) begin
					cur_job = pending_jobs.pop_front();
					req_ch.valid            <= 1'b1;
					req_ch.op               <= cur_job.op;
					req_ch.job_tag          <= cur_job.tag;
					req_ch.request_priority <= cur_job.prio;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 30);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Long hold-off of the response side so the block backs up into its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cnt  <= 0;
			hold_done <= 1'b0;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
		end else if (!hold_done && beats_in >= HOLD_AT) begin
			hold_cnt  <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// Receiver: ready follows an 8-bit pattern, indexed by a position counter, that changes each time the counter wraps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_pat    <= 8'hff;
			stall_pos    <= '0;
		end else begin
			stall_pos <= stall_pos + 1'b1;
			if (stall_pos == '1) begin
				case ($urandom_range(0, 3))
					0:       stall_pat <= 8'hff;
					1:       stall_pat <= 8'($urandom) | 8'h01;
					2:       stall_pat <= 8'($urandom) | 8'($urandom) | 8'h01;
					default: stall_pat <= (8'($urandom) & 8'($urandom)) | 8'h01;
				endcase
			end
			rsp_ch.ready <= (hold_cnt == 0) && stall_pat[stall_pos[2:0]];
		end
	end

	// Monitor: compare each response beat with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		job_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_rsp.size() == 0) begin
				$display("%0t: unexpected response status=%0d tag=%h prio=%0d fill=%0d",
					$time, rsp_ch.status, rsp_ch.out_tag, rsp_ch.out_priority,
					rsp_ch.fill_count);
				errors++;
			end else begin
				want = expected_rsp.pop_front();
				if (rsp_ch.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, rsp_ch.status);
					errors++;
				end
				if (rsp_ch.out_tag !== want.tag) begin
					$display("%0t: out_tag expected %h actual %h",
						$time, want.tag, rsp_ch.out_tag);
					errors++;
				end
				if (rsp_ch.out_priority !== want.prio) begin
					$display("%0t: out_priority expected %0d actual %0d",
						$time, want.prio, rsp_ch.out_priority);
					errors++;
				end
				if (rsp_ch.fill_count !== want.fill) begin
					$display("%0t: fill_count expected %0d actual %0d",
						$time, want.fill, rsp_ch.fill_count);
					errors++;
				end
				case (want.status)
					ST_FULL:  n_full++;
					ST_EMPTY: n_empty++;
					default: begin
						if (want.fill > max_fill)
							max_fill = want.fill;
					end
				endcase
			end
		end
	end

	initial begin
		int seg_len;
		int enq_pct;
		int prio_lo;
		int prio_hi;
		int waited;
		beats_in = 0;
		errors   = 0;
		n_enq    = 0;
		n_full   = 0;
		n_deq    = 0;
		n_empty  = 0;
		max_fill = 0;
		arst_n   = 1'b0;

		// directed: empty dequeue, field extremes, ties at both ends of the range
		add_job(OP_DEQ, 16'hffff, 4'hf);
		add_job(OP_ENQ, 16'h0000, 4'h0);
		add_job(OP_ENQ, 16'hffff, 4'hf);
		add_job(OP_ENQ, 16'h1234, 4'h7);
		add_job(OP_ENQ, 16'h5678, 4'h7);
		add_job(OP_ENQ, 16'haaaa, 4'hf);
		add_job(OP_ENQ, 16'h5555, 4'h0);
		repeat (7)
			add_job(OP_DEQ, 16'hffff, 4'hf);
		add_job(OP_ENQ, 16'h8001, 4'h8);
		add_job(OP_DEQ, 16'h0000, 4'h0);
		add_job(OP_DEQ, 16'h0000, 4'h0);

		// fill past full, then drain past empty
		repeat (QUEUE_DEPTH + 12)
			add_job(OP_ENQ, 16'($urandom), 4'($urandom));
		repeat (QUEUE_DEPTH + 12)
			add_job(OP_DEQ, 16'($urandom), 4'($urandom));

		// mixed segments with varying enqueue bias and priority spread
		while (pending_jobs.size() < ITEM_TARGET) begin
			seg_len = $urandom_range(20, 80);
			case ($urandom_range(0, 3))
				0:       enq_pct = 25;
				1:       enq_pct = 50;
				2:       enq_pct = 75;
				default: enq_pct = 95;
			endcase
			if ($urandom_range(0, 1)) begin
				prio_lo = 0;
				prio_hi = 15;
			end else begin
				prio_lo = $urandom_range(0, 13);
				prio_hi = prio_lo + 2;
			end
			repeat (seg_len) begin
				if ($urandom_range(1, 100) <= enq_pct)
					add_job(OP_ENQ, 16'($urandom), 4'($urandom_range(prio_lo, prio_hi)));
				else
					add_job(OP_DEQ, 16'($urandom), 4'($urandom));
			end
		end
		total_jobs = pending_jobs.size();
		foreach (pending_jobs[i]) begin
			if (pending_jobs[i].op == OP_ENQ)
				n_enq++;
			else
				n_deq++;
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		wait (beats_in == total_jobs);
		waited = 0;
		while (expected_rsp.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
		if (expected_rsp.size() != 0) begin
			$display("%0t: %0d responses never arrived", $time, expected_rsp.size());
			errors++;
		end

		$display("Ran %0d jobs: %0d enqueues (%0d dropped full), %0d dequeues (%0d empty).",
			total_jobs, n_enq, n_full, n_deq, n_empty);
		$display("Peak fill %0d of %0d, with one %0d-cycle response hold-off.",
			max_fill, QUEUE_DEPTH, HOLD_CYCLES);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("%0t: timeout with %0d of %0d jobs sent", $time, beats_in, total_jobs);
		$display("DONE: errors detected");
		$finish;
	end

endmodule
